[rtl/least_loaded_dispatcher_macros.svh]
// ----------------------------------------------------------------------------
// Least-loaded dispatcher assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_DISPATCHER_MACROS_SVH
`define LEAST_LOADED_DISPATCHER_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define LLD_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another one in the same cycle.
`define LLD_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A condition that implies another one in the next cycle.
`define LLD_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lld_pkg.sv]
// ----------------------------------------------------------------------------
// Least-loaded dispatcher package
// Codes and the request record passed from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package lld_pkg;

  localparam logic OP_ARRIVAL   = 1'b0;
  localparam logic OP_DEPARTURE = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_INACTIVE = 2'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] job_time;
    logic [2:0]  agent;
    logic [3:0]  live;      // clamped number of active agents
    logic        inactive;  // departure names an agent that is not active
  } req_t;

endpackage

`default_nettype wire

[rtl/lld_front.sv]
// ----------------------------------------------------------------------------
// Dispatcher front end
// Holds the active-agent register, unpacks requests and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_front #(
  parameter int AGENTS = 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_wr_en,
  input  wire [3:0]        cfg_wr_data,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire              in_tuser,
  input  wire [23:0]       in_tdata,
  input  wire              q_full,
  output logic             q_push,
  output lld_pkg::req_t    q_req
);
  import lld_pkg::*;

  localparam logic [3:0] KMAX = (AGENTS > 15) ? 4'd15 : 4'(AGENTS);

  logic [3:0] active_r;
  logic [3:0] live;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 4'd8;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  // Zero behaves as one agent, anything above the build size as all agents.
  always_comb begin
    if (active_r == 4'd0) begin
      live = 4'd1;
    end else if (active_r > KMAX) begin
      live = KMAX;
    end else begin
      live = active_r;
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_req.op       = in_tuser;
    q_req.job_time = in_tdata[15:0];
    q_req.agent    = in_tdata[18:16];
    q_req.live     = live;
    q_req.inactive = (in_tuser == OP_DEPARTURE) && ({1'b0, in_tdata[18:16]} >= live);
  end

endmodule

`default_nettype wire

[rtl/lld_fifo.sv]
// ----------------------------------------------------------------------------
// Dispatcher request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  lld_pkg::req_t    push_req,
  input  wire              pop,
  output logic             full,
  output logic             valid,
  output lld_pkg::req_t    head_req
);
  import lld_pkg::*;

  req_t       slot_r [0:1];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign head_req = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

[rtl/lld_back.sv]
// ----------------------------------------------------------------------------
// Dispatcher back end
// Per-agent queues, workloads and totals; picks agents and forms results.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_back #(
  parameter int AGENTS      = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  input  lld_pkg::req_t    q_req,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire              out_tready,
  output logic [1:0]       out_tuser,
  output logic [87:0]      out_tdata
);
  import lld_pkg::*;

  localparam int AW = (AGENTS > 1) ? $clog2(AGENTS) : 1;
  localparam int LV = (AGENTS > 1) ? $clog2(AGENTS) : 0;
  localparam int NP = 1 << LV;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = 16 + FW;
  localparam int MD = AGENTS * QUEUE_DEPTH;
  localparam int MW = (MD > 1) ? $clog2(MD) : 1;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t          state_r;
  req_t            cur_r;
  logic [AW-1:0]   sel_r;
  logic [15:0]     rd0_r;
  logic [15:0]     rd1_r;
  logic [15:0]     job_mem [0:MD-1];

  logic [LW-1:0]   load_r   [0:AGENTS-1];
  logic [HW-1:0]   head_r   [0:AGENTS-1];
  logic [FW-1:0]   fill_r   [0:AGENTS-1];
  logic [31:0]     served_r [0:AGENTS-1];
  logic [31:0]     busy_r   [0:AGENTS-1];

  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [2:0]      out_agent_r;
  logic            out_start_r;
  logic [15:0]     out_dur_r;
  logic [31:0]     out_served_r;
  logic [31:0]     out_busy_r;

  // Argmin tree over agent loads, lowest index wins a tie.
  logic [LW-1:0]   tv [0:LV][0:NP-1];
  logic [AW-1:0]   ti [0:LV][0:NP-1];
  logic            tok [0:LV][0:NP-1];
  logic [AW-1:0]   best;
  logic [AW-1:0]   req_idx;
  logic [AW+2:0]   agent_ext;

  always_comb begin
    for (int l = 0; l <= LV; l++) begin
      for (int n = 0; n < NP; n++) begin
        tv[l][n]  = '0;
        ti[l][n]  = '0;
        tok[l][n] = 1'b0;
      end
    end
    for (int n = 0; n < NP; n++) begin
      if (n < AGENTS) begin
        tv[0][n]  = load_r[n];
        tok[0][n] = (n < int'(q_req.live));
      end
      ti[0][n] = AW'(n);
    end
    for (int l = 0; l < LV; l++) begin
      for (int n = 0; n < (NP >> (l + 1)); n++) begin
        if (tok[l][2*n+1] && (!tok[l][2*n] || (tv[l][2*n+1] < tv[l][2*n]))) begin
          tv[l+1][n]  = tv[l][2*n+1];
          ti[l+1][n]  = ti[l][2*n+1];
          tok[l+1][n] = 1'b1;
        end else begin
          tv[l+1][n]  = tv[l][2*n];
          ti[l+1][n]  = ti[l][2*n];
          tok[l+1][n] = tok[l][2*n] || tok[l][2*n+1];
        end
      end
    end
    best = ti[LV][0];
  end

  assign agent_ext = {{AW{1'b0}}, q_req.agent};
  assign req_idx   = (q_req.op == OP_ARRIVAL) ? best : agent_ext[AW-1:0];

  // Read addresses for the head job and the one behind it.
  logic [HW-1:0] rd_head;
  logic [HW-1:0] rd_next;
  logic [MW-1:0] rd0_addr;
  logic [MW-1:0] rd1_addr;

  assign rd_head  = head_r[req_idx];
  assign rd_next  = (rd_head == HW'(QUEUE_DEPTH - 1)) ? '0 : rd_head + HW'(1);
  assign rd0_addr = MW'(req_idx) * MW'(QUEUE_DEPTH) + MW'(rd_head);
  assign rd1_addr = MW'(req_idx) * MW'(QUEUE_DEPTH) + MW'(rd_next);

  assign q_pop = q_valid && (state_r == S_IDLE) && (!out_valid_r || out_tready);

  // Execute-stage values for the latched request.
  logic [FW-1:0] c_fill;
  logic [HW-1:0] c_head;
  logic [FW:0]   slot_sum;
  logic [HW-1:0] slot;
  logic [MW-1:0] wr_addr;
  logic          wr_en;
  logic          is_full;
  logic [31:0]   served_inc;
  logic [32:0]   busy_sum;
  logic [31:0]   busy_new;
  logic [LW-1:0] t_ext;
  logic [LW-1:0] load_sub;

  always_comb begin
    c_fill     = fill_r[sel_r];
    c_head     = head_r[sel_r];
    slot_sum   = {1'b0, c_fill} + (FW+1)'(c_head);
    slot       = (slot_sum >= (FW+1)'(QUEUE_DEPTH)) ?
                 HW'(slot_sum - (FW+1)'(QUEUE_DEPTH)) : HW'(slot_sum);
    wr_addr    = MW'(sel_r) * MW'(QUEUE_DEPTH) + MW'(slot);
    is_full    = (c_fill >= FW'(QUEUE_DEPTH));
    wr_en      = (state_r == S_EXEC) && (cur_r.op == OP_ARRIVAL) && !is_full;
    served_inc = (served_r[sel_r] == 32'hFFFF_FFFF) ? served_r[sel_r] : served_r[sel_r] + 32'd1;
    busy_sum   = {1'b0, busy_r[sel_r]} + {17'd0, rd0_r};
    busy_new   = busy_sum[32] ? 32'hFFFF_FFFF : busy_sum[31:0];
    t_ext      = LW'(rd0_r);
    load_sub   = (load_r[sel_r] >= t_ext) ? load_r[sel_r] - t_ext : '0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd0_r <= job_mem[rd0_addr];
      rd1_r <= job_mem[rd1_addr];
    end
    if (wr_en) begin
      job_mem[wr_addr] <= cur_r.job_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AGENTS; i++) begin
        load_r[i]   <= '0;
        head_r[i]   <= '0;
        fill_r[i]   <= '0;
        served_r[i] <= '0;
        busy_r[i]   <= '0;
      end
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cur_r   <= q_req;
            sel_r   <= req_idx;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          out_agent_r <= cur_r.op == OP_ARRIVAL ? 3'(sel_r) : cur_r.agent;
          if (cur_r.op == OP_ARRIVAL) begin
            out_served_r <= served_r[sel_r];
            out_busy_r   <= busy_r[sel_r];
            if (is_full) begin
              out_status_r <= ST_FULL;
              out_start_r  <= 1'b0;
              out_dur_r    <= 16'd0;
            end else begin
              out_status_r  <= ST_OK;
              fill_r[sel_r] <= c_fill + FW'(1);
              load_r[sel_r] <= load_r[sel_r] + LW'(cur_r.job_time);
              // A job landing in an empty queue starts service at once.
              out_start_r   <= (c_fill == '0);
              out_dur_r     <= (c_fill == '0) ? cur_r.job_time : 16'd0;
            end
          end else if (cur_r.inactive) begin
            out_status_r <= ST_INACTIVE;
            out_start_r  <= 1'b0;
            out_dur_r    <= 16'd0;
            out_served_r <= 32'd0;
            out_busy_r   <= 32'd0;
          end else if (c_fill == '0) begin
            out_status_r <= ST_EMPTY;
            out_start_r  <= 1'b0;
            out_dur_r    <= 16'd0;
            out_served_r <= served_r[sel_r];
            out_busy_r   <= busy_r[sel_r];
          end else begin
            out_status_r    <= ST_OK;
            head_r[sel_r]   <= (c_head == HW'(QUEUE_DEPTH - 1)) ? '0 : c_head + HW'(1);
            fill_r[sel_r]   <= c_fill - FW'(1);
            load_r[sel_r]   <= load_sub;
            served_r[sel_r] <= served_inc;
            busy_r[sel_r]   <= busy_new;
            out_served_r    <= served_inc;
            out_busy_r      <= busy_new;
            out_start_r     <= (c_fill != FW'(1));
            out_dur_r       <= (c_fill != FW'(1)) ? rd1_r : 16'd0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'd0, out_busy_r, out_served_r, out_dur_r, out_start_r, out_agent_r};

`include "least_loaded_dispatcher_macros.svh"

  `LLD_NEXT(a_exec_one_cycle, state_r == S_EXEC, state_r == S_IDLE, "execute held too long")
  `LLD_IMPLY(a_slot_free, state_r == S_EXEC, !out_valid_r, "result overwrites pending result")
  `LLD_CHECK(a_fill_bound, fill_r[sel_r] <= FW'(QUEUE_DEPTH), "queue fill above depth")
  `LLD_IMPLY(a_pop_idle, q_pop, state_r == S_IDLE && q_valid, "pop outside idle")

endmodule

`default_nettype wire

[rtl/least_loaded_dispatcher.sv]
// Flow: an accepted request is written to the queue, then the back end pops
// it, picks the agent and reads the head jobs, then applies the update.
// The back end finishes each request with its pick/read and update/write steps
// on the single job memory before taking the next, and waits on a held result.
// Reset: rst_n is synchronous, active low; all loads, fills and totals clear,
// the active-agent register returns to 8, and job memory contents are kept.
`default_nettype none

// ----------------------------------------------------------------------------
// Least-loaded dispatcher
// Sends arriving jobs to the active agent with the least pending work and
// retires head jobs on departures, reporting per-agent totals.
// ----------------------------------------------------------------------------
module least_loaded_dispatcher #(
  parameter int AGENTS      = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  // Configuration: active agent count.
  input  wire         cfg_wr_en,
  input  wire [3:0]   cfg_wr_data,
  // Request channel.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire         in_tuser,   // [0] opcode
  input  wire [23:0]  in_tdata,   // [15:0] job_time, [18:16] agent, zero fill
  // Result channel.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [87:0] out_tdata   // [2:0] chosen_agent, [3] start_service,
                                  // [19:4] start_duration, [51:20] served_total,
                                  // [83:52] busy_total, zero fill
);
  import lld_pkg::*;

  req_t push_req;
  req_t head_req;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_valid;

  // The front end holds the active-agent register and classifies requests; all per-agent state lives in the back end.
  lld_front #(
    .AGENTS (AGENTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_req       (push_req)
  );

  // The short queue lets new requests land while the back end is busy or
  // its result is still waiting to be taken.
  lld_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head_req (head_req)
  );

  // The back end picks the agent, reads the job memory, then applies the
  // update and loads the result register.
  lld_back #(
    .AGENTS      (AGENTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_req      (head_req),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
